// ----- sv/zbl_pkg.sv -----
// Shared types and constants for the z-buffered line raster block.
package zbl_pkg;

  // Function codes carried by an input transaction
  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  // Depth extremes, Q16.16
  localparam logic [31:0] DEPTH_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] DEPTH_MIN = 32'h8000_0000;

  // Saturation limit of the drawn pixel count
  localparam logic [8:0] CNT_MAX = 9'd511;

  // Shared divider operand widths
  localparam int DIV_NW = 35;
  localparam int DIV_DW = 34;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_RD_REQ,
    S_RD_DATA,
    S_INV0_GO,
    S_INV0_WAIT,
    S_INV1_GO,
    S_INV1_WAIT,
    S_STEP_GO,
    S_STEP_WAIT,
    S_PIX_RD,
    S_PIX_WR,
    S_DONE
  } state_t;

endpackage

// ----- sv/zbl_if.sv -----
// Valid/ready channel interfaces: command input, result output, configuration write.
interface zbl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  x0;
  logic [7:0]  y0;
  logic signed [31:0] z0;
  logic [7:0]  x1;
  logic [7:0]  y1;
  logic signed [31:0] z1;
  logic [23:0] line_color;

  modport source(output valid, func, x0, y0, z0, x1, y1, z1, line_color, input ready);
  modport sink(input valid, func, x0, y0, z0, x1, y1, z1, line_color, output ready);
endinterface

interface zbl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [8:0]  pixels_drawn;
  logic [23:0] pixel_color;
  logic signed [31:0] pixel_inv_depth;

  modport source(output valid, status, pixels_drawn, pixel_color, pixel_inv_depth,
                 input ready);
  modport sink(input valid, status, pixels_drawn, pixel_color, pixel_inv_depth,
               output ready);
endinterface

interface zbl_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- sv/zbl_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module zbl_div (
  input  logic                clk,
  input  logic                rst_n,
  input  zbl_pkg::div_req_t   req,
  output zbl_pkg::div_rsp_t   rsp
);

  localparam int NW = zbl_pkg::DIV_NW;
  localparam int DW = zbl_pkg::DIV_DW;
  localparam int CW = $clog2(NW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fits;

  // trial subtract of the shifted partial remainder
  assign trial = {rem_r, acc_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
      acc_nxt = {acc_r[NW-2:0], fits};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = acc_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- sv/z_buffered_line_raster_core.sv -----
// Z-buffered line rasterizer: color and inverse-depth stores, draw/read/clear commands.
// Usage:
//  - in_bus carries one command per transaction: draw line (func 0), read pixel
//    at x0,y0 (func 1) or clear both stores (func 2). One command is worked on
//    at a time; in_bus.ready is high only while the block is idle.
//  - out_bus returns exactly one result per command: status, pixels drawn, and
//    for a read the stored color and inverse depth.
//  - cfg_bus writes the background color used by clear; always ready.
// Sequence (accept to result valid):
//  - draw: a decode state and three divisions on the shared divider (two
//    endpoint inverse depths and the depth step), then a read state and a
//    compare/write state per pixel, n+1 pixels for a major-axis extent n.
//    Coordinate or zero-depth errors and single-point lines return straight from decode.
//  - read: decode, store read, data capture; clear: one store entry per cycle.
//  Each pixel takes a store read, then a compare and a conditional write.
// Reset: a clearing pass over all WIDTH*HEIGHT entries fills the stores (depth maximum,
// color 0); in_bus.ready stays low until it ends. Config writes are taken.
// A stalled receiver holds the result on out_bus; no new command is taken meanwhile.
module z_buffered_line_raster_core #(
  parameter int WIDTH  = 256,
  parameter int HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  zbl_in_if.sink      in_bus,
  zbl_out_if.source   out_bus,
  zbl_cfg_if.sink     cfg_bus
);

  localparam int NPIX = WIDTH * HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int MW   = 56;

  zbl_pkg::state_t state_r, state_nxt;

  // Latched command
  logic [1:0]  func_r;
  logic [7:0]  x0_r, y0_r, x1_r, y1_r;
  logic [31:0] z0_r, z1_r;
  logic [23:0] color_r;
  logic [23:0] bg_r;

  // Clearing pass
  logic [AW-1:0] clr_r;
  logic [23:0]   clr_color_r;
  logic          clr_op_r;

  // Walk geometry and trackers
  logic [7:0]        n_r;
  logic              steep_r;
  logic              maj_dn_r;
  logic              swap_r;
  logic [7:0]        maj_r;
  logic [7:0]        rem_r;
  logic signed [9:0] mq_r;
  logic [9:0]        mr_r;
  logic signed [9:0] mqd_r;
  logic [9:0]        mrd2_r;
  logic [31:0]       w0_r, w1_r;
  logic signed [33:0] wq_r;
  logic [9:0]        wr_r;
  logic signed [33:0] wqd_r;
  logic [9:0]        wrd2_r;
  logic [31:0]       v_r;
  logic [AW-1:0]     addr_r;

  // Result registers
  logic [1:0]  status_r;
  logic [8:0]  cnt_r;
  logic [23:0] ocolor_r;
  logic [31:0] odepth_r;

  // Store
  logic [MW-1:0] mem_r [NPIX];
  logic [MW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  zbl_pkg::div_req_t div_req;
  zbl_pkg::div_rsp_t div_rsp;

  zbl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Command decode and geometry, from the latched endpoints
  logic              swap;
  logic [7:0]        sx, sy, ex, ey, dx, ady, nn;
  logic signed [8:0] dy, dm, nn9;
  logic              steep, range_bad, zero_bad, rd_bad;
  logic signed [9:0] mqd;
  logic [9:0]        mrd2;

  always_comb begin
    swap  = x0_r > x1_r;
    sx    = swap ? x1_r : x0_r;
    sy    = swap ? y1_r : y0_r;
    ex    = swap ? x0_r : x1_r;
    ey    = swap ? y0_r : y1_r;
    dx    = ex - sx;
    dy    = $signed({1'b0, ey}) - $signed({1'b0, sy});
    ady   = dy[8] ? 8'(-dy) : dy[7:0];
    steep = ady > dx;
    nn    = steep ? ady : dx;
    nn9   = $signed({1'b0, nn});
    dm    = steep ? $signed({1'b0, dx}) : dy;
    // floor division of the minor extent by n
    if (dm == nn9) begin
      mqd  = 10'sd1;
      mrd2 = '0;
    end else if (dm == -nn9) begin
      mqd  = -10'sd1;
      mrd2 = '0;
    end else if (!dm[8]) begin
      mqd  = '0;
      mrd2 = {1'b0, dm[7:0], 1'b0};
    end else begin
      mqd  = -10'sd1;
      mrd2 = {1'b0, 8'(nn9 + dm), 1'b0};
    end
    rd_bad    = (32'(x0_r) >= 32'(WIDTH)) || (32'(y0_r) >= 32'(HEIGHT));
    range_bad = rd_bad || (32'(x1_r) >= 32'(WIDTH)) || (32'(y1_r) >= 32'(HEIGHT));
    zero_bad  = (z0_r == '0) || (z1_r == '0);
  end

  // Endpoint inverse depth operands and saturation
  logic [31:0] zsel, zmag, w_sat;
  logic        zneg;
  logic [34:0] qq;

  always_comb begin
    zsel = ((state_r == zbl_pkg::S_INV1_GO) || (state_r == zbl_pkg::S_INV1_WAIT)) ?
           z1_r : z0_r;
    zneg = zsel[31];
    zmag = zneg ? (~zsel + 32'd1) : zsel;
    qq   = div_rsp.quo;
    if (!zneg) begin
      w_sat = (qq > 35'(zbl_pkg::DEPTH_MAX)) ? zbl_pkg::DEPTH_MAX : qq[31:0];
    end else begin
      w_sat = (qq > 35'(zbl_pkg::DEPTH_MIN)) ? zbl_pkg::DEPTH_MIN : (~qq[31:0] + 32'd1);
    end
  end

  // Depth step d = wb - wa, walk order
  logic [31:0]        wa, wb;
  logic signed [32:0] d33;
  logic               dneg;
  logic [32:0]        dabs;
  logic signed [33:0] wqd;
  logic [9:0]         wrd2;
  logic [7:0]         rr8;

  always_comb begin
    wa   = swap_r ? w1_r : w0_r;
    wb   = swap_r ? w0_r : w1_r;
    d33  = $signed({wb[31], wb}) - $signed({wa[31], wa});
    dneg = d33[32];
    dabs = dneg ? 33'(-d33) : d33;
    rr8  = div_rsp.rem[7:0];
    if (!dneg) begin
      wqd  = $signed(div_rsp.quo[33:0]);
      wrd2 = {1'b0, rr8, 1'b0};
    end else if (rr8 == '0) begin
      wqd  = -$signed(div_rsp.quo[33:0]);
      wrd2 = '0;
    end else begin
      wqd  = -$signed(div_rsp.quo[33:0]) - 34'sd1;
      wrd2 = {1'b0, 8'(n_r - rr8), 1'b0};
    end
  end

  // Current pixel and its interpolated inverse depth
  logic [7:0]         px, py;
  logic [AW-1:0]      pix_addr;
  logic               wnonneg;
  logic signed [33:0] vq;
  logic [9:0]         two_n;

  always_comb begin
    two_n    = {1'b0, n_r, 1'b0};
    px       = (state_r == zbl_pkg::S_RD_REQ) ? x0_r : (steep_r ? mq_r[7:0] : maj_r);
    py       = (state_r == zbl_pkg::S_RD_REQ) ? y0_r : (steep_r ? maj_r : mq_r[7:0]);
    pix_addr = AW'(AW'(py) * AW'(WIDTH)) + AW'(px);
    wnonneg  = (wq_r > 34'sd0) || ((wq_r == 34'sd0) && (wr_r >= 10'(n_r)));
    vq       = wnonneg ? wq_r : (wq_r + ((wr_r != '0) ? 34'sd0 : -34'sd1));
  end

  // Tracker advance
  logic [9:0]         msum, wsum;
  logic               mwrap, wwrap;
  logic signed [9:0]  mq_step;
  logic signed [33:0] wq_step;
  logic               hit;

  always_comb begin
    msum    = mr_r + mrd2_r;
    mwrap   = msum >= two_n;
    mq_step = mq_r + mqd_r + (mwrap ? 10'sd1 : 10'sd0);
    wsum    = wr_r + wrd2_r;
    wwrap   = wsum >= two_n;
    wq_step = wq_r + wqd_r + (wwrap ? 34'sd1 : 34'sd0);
    hit     = $signed(v_r) < $signed(rdata_r[31:0]);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zbl_pkg::S_CLEAR: begin
        if (clr_r == AW'(NPIX - 1)) begin
          state_nxt = clr_op_r ? zbl_pkg::S_DONE : zbl_pkg::S_IDLE;
        end
      end
      zbl_pkg::S_IDLE: begin
        if (in_bus.valid) begin
          state_nxt = zbl_pkg::S_SETUP;
        end
      end
      zbl_pkg::S_SETUP: begin
        unique case (func_r)
          zbl_pkg::FUNC_DRAW: begin
            if (range_bad || zero_bad || (nn == '0)) begin
              state_nxt = zbl_pkg::S_DONE;
            end else begin
              state_nxt = zbl_pkg::S_INV0_GO;
            end
          end
          zbl_pkg::FUNC_READ:  state_nxt = rd_bad ? zbl_pkg::S_DONE : zbl_pkg::S_RD_REQ;
          zbl_pkg::FUNC_CLEAR: state_nxt = zbl_pkg::S_CLEAR;
          default:             state_nxt = zbl_pkg::S_DONE;
        endcase
      end
      zbl_pkg::S_RD_REQ:    state_nxt = zbl_pkg::S_RD_DATA;
      zbl_pkg::S_RD_DATA:   state_nxt = zbl_pkg::S_DONE;
      zbl_pkg::S_INV0_GO:   state_nxt = zbl_pkg::S_INV0_WAIT;
      zbl_pkg::S_INV0_WAIT: if (div_rsp.done) state_nxt = zbl_pkg::S_INV1_GO;
      zbl_pkg::S_INV1_GO:   state_nxt = zbl_pkg::S_INV1_WAIT;
      zbl_pkg::S_INV1_WAIT: if (div_rsp.done) state_nxt = zbl_pkg::S_STEP_GO;
      zbl_pkg::S_STEP_GO:   state_nxt = zbl_pkg::S_STEP_WAIT;
      zbl_pkg::S_STEP_WAIT: if (div_rsp.done) state_nxt = zbl_pkg::S_PIX_RD;
      zbl_pkg::S_PIX_RD:    state_nxt = zbl_pkg::S_PIX_WR;
      zbl_pkg::S_PIX_WR: begin
        state_nxt = (rem_r == '0) ? zbl_pkg::S_DONE : zbl_pkg::S_PIX_RD;
      end
      zbl_pkg::S_DONE: begin
        if (out_bus.ready) begin
          state_nxt = zbl_pkg::S_IDLE;
        end
      end
      default: state_nxt = zbl_pkg::S_IDLE;
    endcase
  end

  // Control outputs: handshakes, divider requests, store port
  always_comb begin
    in_bus.ready  = 1'b0;
    out_bus.valid = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {1'b0, 1'b1, 1'b0, zmag};
    div_req.den   = {1'b0, zmag, 1'b0};
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = {color_r, v_r};
    mem_raddr     = pix_addr;
    unique case (state_r)
      zbl_pkg::S_IDLE: in_bus.ready = 1'b1;
      zbl_pkg::S_DONE: out_bus.valid = 1'b1;
      zbl_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {clr_color_r, zbl_pkg::DEPTH_MAX};
      end
      zbl_pkg::S_INV0_GO, zbl_pkg::S_INV1_GO: div_req.start = 1'b1;
      zbl_pkg::S_STEP_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {2'b00, dabs};
        div_req.den   = {26'd0, n_r};
      end
      zbl_pkg::S_PIX_WR: mem_we = hit;
      default: ;
    endcase
  end

  assign cfg_bus.ready         = 1'b1;
  assign out_bus.status        = status_r;
  assign out_bus.pixels_drawn  = cnt_r;
  assign out_bus.pixel_color   = ocolor_r;
  assign out_bus.pixel_inv_depth = $signed(odepth_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zbl_pkg::S_CLEAR;
      clr_r       <= '0;
      clr_color_r <= '0;
      clr_op_r    <= 1'b0;
      bg_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid) begin
        bg_r <= cfg_bus.data;
      end
      if (state_r == zbl_pkg::S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end else if (state_r == zbl_pkg::S_SETUP) begin
        clr_r       <= '0;
        clr_color_r <= bg_r;
        clr_op_r    <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      zbl_pkg::S_IDLE: begin
        func_r  <= in_bus.func;
        x0_r    <= in_bus.x0;
        y0_r    <= in_bus.y0;
        z0_r    <= in_bus.z0;
        x1_r    <= in_bus.x1;
        y1_r    <= in_bus.y1;
        z1_r    <= in_bus.z1;
        color_r <= in_bus.line_color;
      end
      zbl_pkg::S_SETUP: begin
        status_r <= zbl_pkg::STAT_OK;
        cnt_r    <= '0;
        ocolor_r <= '0;
        odepth_r <= '0;
        if (func_r == zbl_pkg::FUNC_DRAW) begin
          if (range_bad) begin
            status_r <= zbl_pkg::STAT_RANGE;
          end else if (zero_bad) begin
            status_r <= zbl_pkg::STAT_ZERO;
          end
        end else if ((func_r == zbl_pkg::FUNC_READ) && rd_bad) begin
          status_r <= zbl_pkg::STAT_RANGE;
        end
        n_r      <= nn;
        rem_r    <= nn;
        steep_r  <= steep;
        maj_dn_r <= steep && dy[8];
        swap_r   <= swap;
        maj_r    <= steep ? sy : sx;
        mq_r     <= $signed({2'b00, steep ? sx : sy});
        mr_r     <= {2'b00, nn};
        mqd_r    <= mqd;
        mrd2_r   <= mrd2;
      end
      zbl_pkg::S_RD_DATA: begin
        ocolor_r <= rdata_r[55:32];
        odepth_r <= rdata_r[31:0];
      end
      zbl_pkg::S_INV0_WAIT: if (div_rsp.done) w0_r <= w_sat;
      zbl_pkg::S_INV1_WAIT: if (div_rsp.done) w1_r <= w_sat;
      zbl_pkg::S_STEP_WAIT: begin
        if (div_rsp.done) begin
          wqd_r  <= wqd;
          wrd2_r <= wrd2;
          wq_r   <= $signed({{2{wa[31]}}, wa});
          wr_r   <= {2'b00, n_r};
        end
      end
      zbl_pkg::S_PIX_RD: begin
        addr_r <= pix_addr;
        v_r    <= vq[31:0];
      end
      zbl_pkg::S_PIX_WR: begin
        if (hit && (cnt_r != zbl_pkg::CNT_MAX)) begin
          cnt_r <= cnt_r + 9'd1;
        end
        rem_r <= rem_r - 8'd1;
        maj_r <= maj_dn_r ? (maj_r - 8'd1) : (maj_r + 8'd1);
        mq_r  <= mq_step;
        mr_r  <= mwrap ? (msum - two_n) : msum;
        wq_r  <= wq_step;
        wr_r  <= wwrap ? (wsum - two_n) : wsum;
      end
      default: ;
    endcase
  end

  // Color and inverse-depth store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem_r[mem_raddr];
  end

`ifndef NO_ASSERTIONS
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_minor_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zbl_pkg::S_PIX_RD) |-> (mr_r < two_n))
    else $error("minor remainder out of range");

  a_depth_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zbl_pkg::S_PIX_RD) |-> (wr_r < two_n))
    else $error("depth remainder out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zbl_pkg::S_PIX_WR) |-> ((10'(cnt_r) + 10'(rem_r)) <= 10'(n_r)))
    else $error("pixel count exceeds pixels walked");
`endif

endmodule
